// ===== src/fcpm_pkg.sv =====
// Shared types, constants and helpers for the frame classifier.
package fcpm_pkg;

    localparam int PATTERN_BYTES_DEF = 16;
    localparam int SNAP_BYTES_DEF    = 1518;
    localparam int WINDOW_BYTES      = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [15:0] ARP_KIND  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;

    // Configuration register indexes.
    localparam logic [7:0] REG_FILTER_ENABLE  = 8'd0;
    localparam logic [7:0] REG_PATTERN_LENGTH = 8'd1;
    localparam logic [7:0] REG_PATTERN_LOW    = 8'd2;
    localparam logic [7:0] REG_PATTERN_HIGH   = 8'd3;

    typedef enum logic [2:0] {
        CLS_ARP     = 3'd0,
        CLS_TCP     = 3'd1,
        CLS_UDP     = 3'd2,
        CLS_ICMP    = 3'd3,
        CLS_UNKNOWN = 3'd4
    } frame_class_t;

    typedef struct packed {
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_kind;
        logic [15:0] payload_length;
        logic [7:0]  payload_offset;
        logic        tcp_header_bad;
        logic        frame_pass;
        frame_class_t frame_class;
    } result_t;

    typedef struct packed {
        logic [7:0]  offset;
        logic [15:0] length;
    } geometry_t;

    // Class from the ethertype and the IPv4 protocol byte.
    function automatic frame_class_t classify(input logic [15:0] kind, input logic [7:0] proto);
        frame_class_t c;
        if (kind == ARP_KIND)          c = CLS_ARP;
        else if (proto == PROTO_TCP)   c = CLS_TCP;
        else if (proto == PROTO_UDP)   c = CLS_UDP;
        else if (proto == PROTO_ICMP)  c = CLS_ICMP;
        else                           c = CLS_UNKNOWN;
        return c;
    endfunction

    // Payload start and length; negative lengths clamp to zero.
    function automatic geometry_t geometry(input frame_class_t cls, input logic [3:0] ihw,
                                           input logic [3:0] thw, input logic [15:0] wl,
                                           input logic [15:0] tl);
        geometry_t g;
        logic signed [17:0] ih;
        logic signed [17:0] th;
        logic signed [17:0] n;
        ih = $signed({12'd0, ihw, 2'b00});
        th = $signed({12'd0, thw, 2'b00});
        n = '0;
        g.offset = '0;
        unique case (cls)
            CLS_ARP: begin
                g.offset = 8'd22;
                n = $signed({2'b00, wl}) - 18'sd14;
            end
            CLS_TCP: begin
                g.offset = 8'd14 + ih[7:0] + th[7:0];
                n = $signed({2'b00, tl}) - ih - th;
            end
            CLS_UDP: begin
                g.offset = 8'd22 + ih[7:0];
                n = $signed({2'b00, tl}) - ih - 18'sd8;
            end
            CLS_ICMP: begin
                g.offset = 8'd22 + ih[7:0];
                n = $signed({2'b00, wl}) - ih - 18'sd14;
            end
            default: begin
                g.offset = '0;
                n = '0;
            end
        endcase
        g.length = n[17] ? 16'd0 : n[15:0];
        return g;
    endfunction

endpackage

// ===== src/fcpm_front.sv =====
// Front end: captures header fields byte by byte, runs the window match, builds results.
module fcpm_front #(
    parameter int PATTERN_BYTES = fcpm_pkg::PATTERN_BYTES_DEF,
    parameter int SNAP_BYTES    = fcpm_pkg::SNAP_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       data_byte,
    input  logic             frame_last,
    input  logic [15:0]      wire_length,
    input  logic             cfg_write,
    input  logic [7:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output logic             push,
    output fcpm_pkg::result_t result
);
    import fcpm_pkg::*;

    localparam int PAT_W = PATTERN_BYTES * 8;

    logic        filt_reg, filt_next;
    logic [4:0]  plen_reg, plen_next;
    logic [PAT_W-1:0] pat_reg, pat_next;

    logic [15:0] idx_reg, idx_next;
    logic [7:0]  win_reg [WINDOW_BYTES], win_next [WINDOW_BYTES];
    logic [15:0] wl_reg, wl_next;
    logic [15:0] kind_reg, kind_next;
    logic [47:0] smac_reg, smac_next;
    logic [47:0] dmac_reg, dmac_next;
    logic [3:0]  ihw_reg, ihw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] tl_reg, tl_next;
    logic [31:0] sip_reg, sip_next;
    logic [31:0] dip_reg, dip_next;
    logic [31:0] ports_reg, ports_next;
    logic [3:0]  thw_reg, thw_next;
    logic        seen_reg, seen_next;

    logic [127:0]  pat_full;
    logic [127:0]  pat16;
    logic [15:0]   i;
    logic          rx;
    logic [15:0]   t0;
    logic [15:0]   rel;
    frame_class_t  cls;
    geometry_t     geo;
    logic [16:0]   pend;
    logic [4:0]    plen;
    logic          ready;
    logic          scan_en;
    logic          hit_any;
    logic          hit;
    logic [16:0]   s_ext;
    logic [3:0]    slot;

    // Configuration registers.
    always_comb begin
        filt_next = filt_reg;
        plen_next = plen_reg;
        pat_full  = 128'(pat_reg);
        if (cfg_write) begin
            unique case (cfg_index)
                REG_FILTER_ENABLE:  filt_next = cfg_data[0];
                REG_PATTERN_LENGTH: plen_next = cfg_data[4:0];
                REG_PATTERN_LOW:    pat_full[63:0] = cfg_data;
                REG_PATTERN_HIGH:   pat_full[127:64] = cfg_data;
                default: ;
            endcase
        end
        pat_next = pat_full[PAT_W-1:0];
    end

    // Header capture, window update and pattern search for one beat.
    always_comb begin
        i  = idx_reg;
        rx = (i < 16'(SNAP_BYTES));
        wl_next    = (i == 16'd0) ? wire_length : wl_reg;
        kind_next  = kind_reg;
        smac_next  = smac_reg;
        dmac_next  = dmac_reg;
        ihw_next   = ihw_reg;
        proto_next = proto_reg;
        tl_next    = tl_reg;
        sip_next   = sip_reg;
        dip_next   = dip_reg;
        ports_next = ports_reg;
        thw_next   = thw_reg;
        for (int w = 0; w < WINDOW_BYTES; w++) win_next[w] = win_reg[w];
        if (rx) begin
            if (i < 16'd6)        dmac_next[(3'd5 - i[2:0]) * 8 +: 8] = data_byte;
            else if (i < 16'd12)  smac_next[(4'd11 - i[3:0]) * 8 +: 8] = data_byte;
            else if (i == 16'd12) kind_next[15:8] = data_byte;
            else if (i == 16'd13) kind_next[7:0] = data_byte;
            else if (i == 16'd14) ihw_next = data_byte[3:0];
            else if (i == 16'd16) tl_next[15:8] = data_byte;
            else if (i == 16'd17) tl_next[7:0] = data_byte;
            else if (i == 16'd23) proto_next = data_byte;
            else if (i >= 16'd26 && i < 16'd30)
                sip_next[{2'(2'd1 - i[1:0]), 3'b000} +: 8] = data_byte;
            else if (i >= 16'd30 && i < 16'd34)
                dip_next[{2'(2'd1 - i[1:0]), 3'b000} +: 8] = data_byte;
            win_next[i[3:0]] = data_byte;
        end
        t0  = 16'd14 + {10'd0, ihw_next, 2'b00};
        rel = i - t0;
        if (rx && i >= t0 && i < t0 + 16'd4) ports_next[(2'd3 - rel[1:0]) * 8 +: 8] = data_byte;
        if (rx && i == t0 + 16'd12) thw_next = data_byte[7:4];

        cls  = classify(kind_next, proto_next);
        geo  = geometry(cls, ihw_next, thw_next, wl_next, tl_next);
        pend = {9'd0, geo.offset} + {1'b0, geo.length};
        plen = (plen_reg > 5'(PATTERN_BYTES)) ? 5'(PATTERN_BYTES) : plen_reg;
        ready = (i >= 16'd13) && (cls == CLS_ARP || (i >= 16'd23 &&
                (cls != CLS_TCP || i >= 16'd26 + {10'd0, ihw_next, 2'b00})));
        scan_en = rx && (ready || frame_last || i == 16'(SNAP_BYTES - 1)) &&
                  cls != CLS_UNKNOWN;

        // Every start within the window ending at this byte is tested at once.
        pat16   = 128'(pat_reg);
        hit_any = 1'b0;
        for (int d = 0; d < WINDOW_BYTES; d++) begin
            s_ext = {1'b0, i} - 17'(d);
            hit = (i >= 16'(d)) && ({1'b0, plen} <= 6'(d + 1)) &&
                  (s_ext >= {9'd0, geo.offset}) && (s_ext < pend) &&
                  (s_ext + {12'd0, plen} <= pend);
            for (int k = 0; k < WINDOW_BYTES; k++) begin
                slot = i[3:0] - 4'(d) + 4'(k);
                if (5'(k) < plen && win_next[slot] != pat16[k*8 +: 8]) hit = 1'b0;
            end
            hit_any = hit_any | hit;
        end
        seen_next = seen_reg | (scan_en & hit_any);

        idx_next = (idx_reg == 16'hffff) ? idx_reg : idx_reg + 16'd1;
    end

    // Result built from the state after the last beat of a frame.
    always_comb begin
        push                  = in_accept & frame_last;
        result.frame_class    = cls;
        result.frame_pass     = (cls != CLS_UNKNOWN) && (!filt_reg || seen_next);
        result.tcp_header_bad = (cls == CLS_TCP) && (thw_next < 4'd5);
        result.payload_offset = geo.offset;
        result.payload_length = geo.length;
        result.ether_kind     = kind_next;
        result.source_mac     = smac_next;
        result.dest_mac       = dmac_next;
        result.source_ip      = (cls == CLS_TCP || cls == CLS_UDP || cls == CLS_ICMP) ?
                                sip_next : 32'd0;
        result.dest_ip        = (cls == CLS_TCP || cls == CLS_UDP || cls == CLS_ICMP) ?
                                dip_next : 32'd0;
        result.source_port    = (cls == CLS_TCP || cls == CLS_UDP) ? ports_next[31:16] : 16'd0;
        result.dest_port      = (cls == CLS_TCP || cls == CLS_UDP) ? ports_next[15:0] : 16'd0;
    end

    // Configuration and frame state registers; the last beat clears the frame state for the next frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= 1'b0;
            plen_reg <= '0;
            pat_reg  <= '0;
        end else begin
            filt_reg <= filt_next;
            plen_reg <= plen_next;
            pat_reg  <= pat_next;
        end
        if (!aresetn || (in_accept && frame_last)) begin
            idx_reg   <= '0;
            wl_reg    <= '0;
            kind_reg  <= '0;
            smac_reg  <= '0;
            dmac_reg  <= '0;
            ihw_reg   <= '0;
            proto_reg <= '0;
            tl_reg    <= '0;
            sip_reg   <= '0;
            dip_reg   <= '0;
            ports_reg <= '0;
            thw_reg   <= '0;
            seen_reg  <= 1'b0;
            for (int w = 0; w < WINDOW_BYTES; w++) win_reg[w] <= '0;
        end else if (in_accept) begin
            idx_reg   <= idx_next;
            wl_reg    <= wl_next;
            kind_reg  <= kind_next;
            smac_reg  <= smac_next;
            dmac_reg  <= dmac_next;
            ihw_reg   <= ihw_next;
            proto_reg <= proto_next;
            tl_reg    <= tl_next;
            sip_reg   <= sip_next;
            dip_reg   <= dip_next;
            ports_reg <= ports_next;
            thw_reg   <= thw_next;
            seen_reg  <= seen_next;
            for (int w = 0; w < WINDOW_BYTES; w++) win_reg[w] <= win_next[w];
        end
    end

    // A frame end always restarts the byte count and the match flag.
    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && frame_last) |=> (idx_reg == 16'd0 && !seen_reg))
        else $error("frame state not cleared after last beat");

    // Pass is never reported for an unknown class.
    a_pass_known: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !(result.frame_pass && result.frame_class == CLS_UNKNOWN))
        else $error("unknown class reported as passing");

endmodule

// ===== src/fcpm_queue.sv =====
// Result queue between the classifier and the output channel; its head drives the beat.
module fcpm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fcpm_pkg::result_t push_data,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output fcpm_pkg::result_t out_data
);
    import fcpm_pkg::*;

    result_t     mem_reg [QUEUE_DEPTH];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    // Pointer and fill count update.
    always_comb begin
        pop       = out_valid && out_ready;
        has_room  = (cnt_reg != 2'(QUEUE_DEPTH));
        out_valid = (cnt_reg != 2'd0);
        out_data  = mem_reg[rd_reg];
        wr_next   = push ? ~wr_reg : wr_reg;
        rd_next   = pop ? ~rd_reg : rd_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (has_room || pop))
        else $error("result pushed into a full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== src/frame_classify_payload_match.sv =====
// Top level of the Ethernet/IPv4 frame classifier with payload pattern filter.
// Frame bytes stream in one per beat, starting at the destination MAC, and the block
// takes one byte every cycle while s_tready is high; the header capture and a 16-start
// window compare finish within the beat's own cycle. The beat with s_tlast set yields
// one result, registered into a two-entry queue that presents it on the m_ side once
// earlier results are taken, so input keeps flowing while a result waits; s_tready
// drops only when both entries are full. Configuration goes through the cfg_ write
// channel, which is always ready, and is meant to be written between frames.
module frame_classify_payload_match #(
    parameter int PATTERN_BYTES = fcpm_pkg::PATTERN_BYTES_DEF,
    parameter int SNAP_BYTES    = fcpm_pkg::SNAP_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], wire_length[23:8]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,   // frame_pass, tcp_header_bad, payload_offset,
                                    // payload_length, ether_kind, source_mac, dest_mac,
                                    // source_ip, dest_ip, source_port, dest_port, zero pad
    output logic [2:0]   m_tuser,   // frame_class
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import fcpm_pkg::*;

    logic    in_accept;
    logic    push;
    logic    has_room;
    result_t front_res;
    result_t head;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = has_room;
    assign cfg_ready = 1'b1;

    fcpm_front #(
        .PATTERN_BYTES(PATTERN_BYTES),
        .SNAP_BYTES(SNAP_BYTES)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_accept(in_accept),
        .data_byte(s_tdata[7:0]),
        .frame_last(s_tlast),
        .wire_length(s_tdata[23:8]),
        .cfg_write(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .result(front_res)
    );

    fcpm_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_data(front_res),
        .has_room(has_room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data(head)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_tuser = head.frame_class;
    assign m_tdata = {6'd0, head.dest_port, head.source_port, head.dest_ip, head.source_ip,
                      head.dest_mac, head.source_mac, head.ether_kind, head.payload_length,
                      head.payload_offset, head.tcp_header_bad, head.frame_pass};

endmodule
